[hw/rtl/atr_pkg.sv]
// ----------------------------------------------------------------------------
// atr_pkg - shared types and constants for the temperature response pipeline
// Fixed widths, constants of the response formula and the stage record types.
// ----------------------------------------------------------------------------
package atr_pkg;

	localparam int TEMP_W        = 16;
	localparam int OFS_W         = 15;
	localparam int RESP_W        = 24;
	localparam int DEN_W         = 31;
	localparam int QX_W          = 38;
	localparam int M_W           = 37;
	localparam int KQ_W          = 5;
	localparam int SH_W          = 6;
	localparam int R30_W         = 30;
	localparam int P_W           = 31;
	localparam int Y_W           = 26;

	localparam int TERMS         = 12;
	localparam int FRONT_STAGES  = 4;
	localparam int REDUCE_STAGES = KQ_W + 2;
	localparam int HORNER_STAGES = 3;
	localparam int FINAL_STAGES  = 2;
	localparam int LATENCY       = FRONT_STAGES + QX_W + REDUCE_STAGES
		+ TERMS * HORNER_STAGES + FINAL_STAGES;

	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd10240;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd3840;
	localparam logic [15:0]              BASE_SHIFT = 16'd2560;
	localparam logic [40:0]              E0_Q32     = 41'd1325255108854;
	localparam logic [31:0]              LN2_Q32    = 32'd2977044472;
	localparam logic [P_W-1:0]           ONE_Q30    = 31'h4000_0000;
	localparam logic [QX_W-1:0]          X_POS_MAX  = 38'd6 << 32;
	localparam logic [QX_W-1:0]          X_NEG_MAX  = 38'd16 << 32;
	localparam logic [OFS_W-1:0]         OFFSET_RST = 15'd11781;
	localparam logic [RESP_W-1:0]        OUT_MAX    = 24'hFF_FFFF;
	localparam logic [SH_W-1:0]          SH_BASE    = 6'd14;

	typedef enum logic [1:0] {
		MODE_CALC = 2'd0,
		MODE_ZERO = 2'd1,
		MODE_SAT  = 2'd2
	} mode_t;

	typedef struct packed {
		logic  vld;
		mode_t mode;
	} ctl_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QX_W-1:0]  low;
		logic [QX_W-1:0]  quot;
		logic             neg;
	} div_t;

	typedef struct packed {
		logic [P_W-1:0]   p;
		logic [R30_W-1:0] r30;
		logic [SH_W-1:0]  sh;
	} exp_t;

endpackage

[hw/rtl/atr_front.sv]
// ----------------------------------------------------------------------------
// atr_front - clamp, special cases and divider operand set-up
// Four stages: clamp and classify, products, rounding add, overflow check.
// ----------------------------------------------------------------------------
module atr_front import atr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic signed [TEMP_W-1:0] temp,
	input  logic [OFS_W-1:0]         offset,
	output ctl_t                     ctl_o,
	output div_t                     div_o
);

	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [15:0]       a_s1, d_s1;
	logic [12:0]       mag_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [DEN_W-1:0]  den_s2, den_s3;
	logic [61:0]       num_s2;
	logic [62:0]       n2_s3;
	div_t              div_s4;

	logic signed [TEMP_W-1:0] tc;
	logic signed [17:0]       d, diff, absd;
	logic [15:0]              a;
	mode_t                    mode1, mode4;
	logic [31:0]              den_full;
	logic [53:0]              em;
	logic                     ovf;

	// stage 1: clamp hot samples, classify cold and bad denominators
	always_comb begin
		tc   = (temp > TEMP_MAX) ? TEMP_MAX : temp;
		d    = 18'(tc) + $signed({3'b000, offset});
		diff = 18'(tc) - $signed({2'b00, BASE_SHIFT});
		absd = diff[17] ? -diff : diff;
		a    = {1'b0, offset} + BASE_SHIFT;
		priority if (temp < TEMP_MIN) begin
			mode1 = MODE_ZERO;
		end else if (d == 18'sd0) begin
			mode1 = MODE_ZERO;
		end else if (d[17]) begin
			mode1 = MODE_SAT;
		end else begin
			mode1 = MODE_CALC;
		end
	end

	always_comb begin
		den_full = 32'(a_s1) * 32'(d_s1);
		em       = 54'(E0_Q32) * 54'(mag_s1);
		ovf      = {6'd0, n2_s3} >= {den_s3, 38'd0};
		mode4    = ctl_s3.mode;
		if (ctl_s3.mode == MODE_CALC && ovf) begin
			mode4 = neg_s3 ? MODE_ZERO : MODE_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= '{vld: in_vld, mode: mode1};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{vld: ctl_s3.vld, mode: mode4};
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= a;
		d_s1   <= d[15:0];
		neg_s1 <= diff[17];
		mag_s1 <= absd[12:0];
		den_s2 <= den_full[DEN_W-1:0];
		num_s2 <= {em, 8'd0};
		neg_s2 <= neg_s1;
		// round to nearest: add half the divisor
		n2_s3  <= 63'(num_s2) + 63'(den_s2 >> 1);
		den_s3 <= den_s2;
		neg_s3 <= neg_s2;
		div_s4 <= '{rem: 31'(n2_s3[62:38]), den: den_s3, low: n2_s3[37:0],
			quot: '0, neg: neg_s3};
	end

	assign ctl_o = ctl_s4;
	assign div_o = div_s4;

endmodule

[hw/rtl/atr_div.sv]
// ----------------------------------------------------------------------------
// atr_div - pipelined restoring divider
// One quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module atr_div import atr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl_i,
	input  div_t div_i,
	output ctl_t ctl_o,
	output div_t div_o
);

	ctl_t ctl_s [QX_W+1];
	div_t div_s [QX_W+1];

	assign ctl_s[0] = ctl_i;
	assign div_s[0] = div_i;

	for (genvar j = 0; j < QX_W; j++) begin : g_bit
		logic [DEN_W:0] sh;
		logic           ge;
		div_t           nxt;

		always_comb begin
			sh       = {div_s[j].rem, div_s[j].low[QX_W-1]};
			ge       = sh >= {1'b0, div_s[j].den};
			nxt      = div_s[j];
			nxt.rem  = ge ? DEN_W'(sh - {1'b0, div_s[j].den}) : sh[DEN_W-1:0];
			nxt.low  = {div_s[j].low[QX_W-2:0], 1'b0};
			nxt.quot = {div_s[j].quot[QX_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			div_s[j+1] <= nxt;
		end
	end

	assign ctl_o = ctl_s[QX_W];
	assign div_o = div_s[QX_W];

endmodule

[hw/rtl/atr_reduce.sv]
// ----------------------------------------------------------------------------
// atr_reduce - range check and reduction by ln2
// Threshold stage, one stage per bit of k, then shift and residue.
// ----------------------------------------------------------------------------
module atr_reduce import atr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl_i,
	input  div_t div_i,
	output ctl_t ctl_o,
	output exp_t ex_o
);

	ctl_t            ctl_s [KQ_W+1];
	logic [M_W-1:0]  m_s   [KQ_W+1];
	logic [KQ_W-1:0] q_s   [KQ_W+1];
	logic            neg_s [KQ_W+1];
	ctl_t            ctl_sr;
	exp_t            ex_sr;

	mode_t           mode1;
	logic [31:0]     rem, r;
	logic [SH_W-1:0] sh;

	always_comb begin
		mode1 = ctl_i.mode;
		if (ctl_i.mode == MODE_CALC) begin
			if (!div_i.neg && div_i.quot > X_POS_MAX) begin
				mode1 = MODE_SAT;
			end else if (div_i.neg && div_i.quot > X_NEG_MAX) begin
				mode1 = MODE_ZERO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= '{vld: ctl_i.vld, mode: mode1};
		end
	end

	always_ff @(posedge clk) begin
		m_s[0]   <= div_i.quot[M_W-1:0];
		q_s[0]   <= '0;
		neg_s[0] <= div_i.neg;
	end

	for (genvar j = 0; j < KQ_W; j++) begin : g_k
		localparam logic [M_W-1:0] STEP = M_W'(LN2_Q32) << (KQ_W - 1 - j);
		logic ge;

		assign ge = m_s[j] >= STEP;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			m_s[j+1]   <= ge ? m_s[j] - STEP : m_s[j];
			q_s[j+1]   <= {q_s[j][KQ_W-2:0], ge};
			neg_s[j+1] <= neg_s[j];
		end
	end

	// negative arguments round k down, leaving a residue in [0, ln2)
	always_comb begin
		rem = m_s[KQ_W][31:0];
		if (!neg_s[KQ_W]) begin
			sh = SH_BASE - SH_W'(q_s[KQ_W]);
			r  = rem;
		end else if (rem == 32'd0) begin
			sh = SH_BASE + SH_W'(q_s[KQ_W]);
			r  = '0;
		end else begin
			sh = SH_BASE + SH_W'(q_s[KQ_W]) + 6'd1;
			r  = LN2_Q32 - rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sr <= '0;
		end else begin
			ctl_sr <= ctl_s[KQ_W];
		end
	end

	always_ff @(posedge clk) begin
		ex_sr <= '{p: ONE_Q30, r30: r[31:2], sh: sh};
	end

	assign ctl_o = ctl_sr;
	assign ex_o  = ex_sr;

endmodule

[hw/rtl/atr_horner_step.sv]
// ----------------------------------------------------------------------------
// atr_horner_step - one term of the exp series, p = 1 + (r * p) / TERM
// Three stages: product, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
module atr_horner_step import atr_pkg::*; #(
	parameter int TERM = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl_i,
	input  exp_t ex_i,
	output ctl_t ctl_o,
	output exp_t ex_o
);

	localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / TERM);
	localparam logic [34:0] TERM_V = 35'(TERM);

	ctl_t           ctl_s1, ctl_s2, ctl_s3;
	exp_t           ex_s1, ex_s2, ex_s3;
	logic [P_W-1:0] v_s1, v_s2, q0_s2;

	logic [60:0]    prod;
	logic [63:0]    rprod;
	logic [34:0]    remv;
	logic [P_W-1:0] qf;

	always_comb begin
		prod  = 61'(ex_i.r30) * 61'(ex_i.p);
		rprod = 64'(v_s1) * 64'(RECIP);
		// the estimate is at most one low
		remv  = 35'(v_s2) - 35'(q0_s2) * TERM_V;
		qf    = q0_s2 + P_W'(remv >= TERM_V);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1   <= ex_i;
		v_s1    <= prod[60:30];
		ex_s2   <= ex_s1;
		v_s2    <= v_s1;
		q0_s2   <= rprod[62:32];
		ex_s3   <= '{p: ONE_Q30 + qf, r30: ex_s2.r30, sh: ex_s2.sh};
	end

	assign ctl_o = ctl_s3;
	assign ex_o  = ex_s3;

endmodule

[hw/rtl/arrhenius_temp_response.sv]
// ----------------------------------------------------------------------------
// arrhenius_temp_response - temperature response factor, one sample per cycle
// Pipeline: 4 set-up, 38 divider, 7 reduction, 36 series and 2 output stages;
//   the divider sets the depth.
// Throughput: one request per cycle; busy is always low.
// The receiver cannot stall: each result shows for one cycle with done.
// Reset clears every valid bit and loads the offset with 11781.
// ----------------------------------------------------------------------------
module arrhenius_temp_response import atr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [TEMP_W-1:0] temp_q8_8,
	input  logic                     cfg_we,
	input  logic [OFS_W-1:0]         cfg_wdata,
	output logic                     done,
	output logic [RESP_W-1:0]        response_q8_16,
	output logic                     saturated
);

	// offset register; write it only while the pipeline is empty (the block does not enforce this)
	logic [OFS_W-1:0] offset_q;

	ctl_t ctl_f, ctl_d, ctl_r;
	div_t div_f, div_d;
	ctl_t ctl_h [TERMS+1];
	exp_t ex_h  [TERMS+1];

	ctl_t           ctl_s1;
	logic [Y_W-1:0] y_s1;
	logic           done_q, sat_q;
	logic [RESP_W-1:0] resp_q;

	logic [38:0]    rnd, ysum;
	logic [RESP_W-1:0] resp_n;
	logic           sat_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// nothing ever holds the pipeline, so a request is always taken
	assign busy = 1'b0;

	// set-up: clamp, classify, form the rounded dividend
	atr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.temp   (temp_q8_8),
		.offset (offset_q),
		.ctl_o  (ctl_f),
		.div_o  (div_f)
	);

	// exponent argument |x| in Q32
	atr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_f),
		.div_i  (div_f),
		.ctl_o  (ctl_d),
		.div_o  (div_d)
	);

	// split x into k*ln2 + r
	atr_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_d),
		.div_i  (div_d),
		.ctl_o  (ctl_r),
		.ex_o   (ex_h[0])
	);

	assign ctl_h[0] = ctl_r;

	// exp(r) by Horner, highest term first
	for (genvar j = 0; j < TERMS; j++) begin : g_term
		atr_horner_step #(
			.TERM (TERMS - j)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_h[j]),
			.ex_i   (ex_h[j]),
			.ctl_o  (ctl_h[j+1]),
			.ex_o   (ex_h[j+1])
		);
	end

	// scale by 2^k into Q16 with round half up
	always_comb begin
		rnd  = 39'd1 << (ex_h[TERMS].sh - 6'd1);
		ysum = (39'(ex_h[TERMS].p) + rnd) >> ex_h[TERMS].sh;
	end

	// pick the final value: computed, forced zero or forced full scale
	always_comb begin
		unique case (ctl_s1.mode)
			MODE_CALC: begin
				if (y_s1 > Y_W'(OUT_MAX)) begin
					resp_n = OUT_MAX;
					sat_n  = 1'b1;
				end else begin
					resp_n = y_s1[RESP_W-1:0];
					sat_n  = 1'b0;
				end
			end
			MODE_SAT: begin
				resp_n = OUT_MAX;
				sat_n  = 1'b1;
			end
			default: begin
				resp_n = '0;
				sat_n  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_h[TERMS];
			done_q <= ctl_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		y_s1   <= ysum[Y_W-1:0];
		resp_q <= resp_n;
		sat_q  <= sat_n;
	end

	assign done           = done_q;
	assign response_q8_16 = resp_q;
	assign saturated      = sat_q;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request did not complete after the fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result strobe without a matching request");

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (response_q8_16 == OUT_MAX))
		else $error("saturated result not at full scale");
`endif

endmodule
